// ===== src/rtt_pkg.sv =====
// shared constants, codes and control/status structs of the retransmit timeout table
// no dependencies; imported by every module of the block

package rtt_pkg;

  localparam int TABLE_DEPTH = 16;
  localparam int MAX_RESULTS = 16;

  localparam int ID_W   = 32;
  localparam int TIME_W = 32;
  localparam int TO_W   = 16;

  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int RES_W = $clog2(MAX_RESULTS + 1);
  localparam int CMP_W = ((CNT_W > RES_W) ? CNT_W : RES_W) + 1;

  localparam logic [TO_W-1:0] RESET_TIMEOUT = TO_W'(10);

  localparam logic [1:0] ACT_SEND  = 2'd0;
  localparam logic [1:0] ACT_REPLY = 2'd1;
  localparam logic [1:0] ACT_CHECK = 2'd2;

  localparam logic [2:0] KIND_QUEUED     = 3'd0;
  localparam logic [2:0] KIND_DROP_EQUAL = 3'd1;
  localparam logic [2:0] KIND_FULL       = 3'd2;
  localparam logic [2:0] KIND_REMOVED    = 3'd3;
  localparam logic [2:0] KIND_NOT_FOUND  = 3'd4;
  localparam logic [2:0] KIND_RESEND     = 3'd5;

  typedef struct packed {
    logic load;    // latch the accepted item, clear resend count
    logic match;   // register compare results over the table
    logic apply;   // insert or remove, write the single result
    logic rotate;  // resend head entry, move it to the tail
  } rtt_cmd_t;

  typedef struct packed {
    logic out_free;  // output register can take a result this cycle
    logic head_go;   // head entry is due for resend
    logic more;      // another entry follows the head one in this check
  } rtt_stat_t;

endpackage

// ===== src/rtt_ctrl.sv =====
// controller state machine of the retransmit timeout table
// depends on rtt_pkg; drives rtt_dp through command and status structs

module rtt_ctrl import rtt_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic [1:0] action,
  output logic       in_stall,
  output rtt_cmd_t   cmd,
  input  rtt_stat_t  stat
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_MATCH = 4'b0010,
    ST_APPLY = 4'b0100,
    ST_CHECK = 4'b1000
  } state_t;

  state_t state, state_next;

  assign in_stall = (state != ST_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          case (action)
            ACT_SEND:  state_next = ST_MATCH;
            ACT_REPLY: state_next = ST_MATCH;
            ACT_CHECK: state_next = ST_CHECK;
            default:   state_next = ST_IDLE;
          endcase
        end
      end
      ST_MATCH: begin
        cmd.match  = 1'b1;
        state_next = ST_APPLY;
      end
      ST_APPLY: begin
        if (stat.out_free) begin
          cmd.apply  = 1'b1;
          state_next = ST_IDLE;
        end
      end
      ST_CHECK: begin
        if (!stat.head_go) begin
          state_next = ST_IDLE;
        end else if (stat.out_free) begin
          cmd.rotate = 1'b1;
          if (!stat.more) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== src/rtt_dp.sv =====
// datapath of the retransmit timeout table: ordered cell row, compares, output register
// depends on rtt_pkg; sequenced by rtt_ctrl

module rtt_dp import rtt_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  rtt_cmd_t          cmd,
  output rtt_stat_t         stat,
  input  logic              cfg_write_en,
  input  logic [TO_W-1:0]   cfg_write_data,
  input  logic [1:0]        action,
  input  logic [ID_W-1:0]   packet_id,
  input  logic [TIME_W-1:0] now_seconds,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [2:0]        kind,
  output logic [ID_W-1:0]   packet_id_res,
  output logic              last
);

  logic [ID_W-1:0]   cell_id   [TABLE_DEPTH];
  logic [TIME_W-1:0] cell_time [TABLE_DEPTH];
  logic [ID_W-1:0]   prev_id   [TABLE_DEPTH];
  logic [TIME_W-1:0] prev_time [TABLE_DEPTH];
  logic [ID_W-1:0]   next_id   [TABLE_DEPTH];
  logic [TIME_W-1:0] next_time [TABLE_DEPTH];

  logic [CNT_W-1:0]  count;
  logic [TO_W-1:0]   timeout;
  logic [RES_W-1:0]  rs_cnt;

  logic [1:0]        item_action;
  logic [ID_W-1:0]   item_id;
  logic [TIME_W-1:0] item_now;

  logic              hit_found;
  logic [IDX_W-1:0]  hit_idx;
  logic              hit_equal;

  logic [TABLE_DEPTH-1:0] eq_vec;
  logic [TABLE_DEPTH-1:0] hit_vec;
  logic                   first_found;
  logic [IDX_W-1:0]       first_idx;
  logic                   first_equal;

  logic              is_send;
  logic              send_ins;
  logic              rem;
  logic [IDX_W-1:0]  ins_pos;
  logic [TIME_W-1:0] head_age;
  logic [TIME_W-1:0] next_age;
  logic              head_exp;
  logic              next_exp;
  logic [CMP_W-1:0]  rs_ext;
  logic [CMP_W-1:0]  cnt_ext;
  logic              out_load;
  logic [2:0]        kind_next;
  logic [ID_W-1:0]   id_next;
  logic              last_next;

  // neighbor taps of each cell
  for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_nb
    if (g > 0) begin : g_prev
      assign prev_id[g]   = cell_id[g-1];
      assign prev_time[g] = cell_time[g-1];
    end else begin : g_prev0
      assign prev_id[g]   = cell_id[g];
      assign prev_time[g] = cell_time[g];
    end
    if (g < TABLE_DEPTH - 1) begin : g_next
      assign next_id[g]   = cell_id[g+1];
      assign next_time[g] = cell_time[g+1];
    end else begin : g_nextl
      assign next_id[g]   = cell_id[g];
      assign next_time[g] = cell_time[g];
    end
  end

  // per-cell compares against the latched item
  always_comb begin
    logic [TIME_W-1:0] d;
    logic              in_use;
    logic              later;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      d          = cell_time[i] - item_now;
      in_use     = (CNT_W'(i) < count);
      later      = (d != '0) && !d[TIME_W-1];
      eq_vec[i]  = (d == '0);
      if (item_action == ACT_SEND) begin
        hit_vec[i] = in_use && (later || eq_vec[i]);
      end else begin
        hit_vec[i] = in_use && (cell_id[i] == item_id);
      end
    end
  end

  // first hit from the head
  always_comb begin
    first_found = 1'b0;
    first_idx   = '0;
    first_equal = 1'b0;
    for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
      if (hit_vec[i]) begin
        first_found = 1'b1;
        first_idx   = IDX_W'(i);
        first_equal = eq_vec[i];
      end
    end
  end

  assign is_send  = (item_action == ACT_SEND);
  assign send_ins = is_send && !(hit_found && hit_equal) && (count != CNT_W'(TABLE_DEPTH));
  assign rem      = !is_send && hit_found;
  assign ins_pos  = hit_found ? hit_idx : count[IDX_W-1:0];

  assign head_age = item_now - cell_time[0];
  assign next_age = item_now - next_time[0];
  assign head_exp = head_age > {{(TIME_W-TO_W){1'b0}}, timeout};
  assign next_exp = next_age > {{(TIME_W-TO_W){1'b0}}, timeout};
  assign rs_ext   = CMP_W'(rs_cnt);
  assign cnt_ext  = CMP_W'(count);

  assign stat.head_go  = (count != '0) && (rs_ext < cnt_ext)
                         && (rs_ext < CMP_W'(MAX_RESULTS)) && head_exp;
  assign stat.more     = ((rs_ext + CMP_W'(1)) < cnt_ext)
                         && ((rs_ext + CMP_W'(1)) < CMP_W'(MAX_RESULTS)) && next_exp;
  assign stat.out_free = !out_valid || !out_stall;

  assign out_load = cmd.apply || cmd.rotate;

  always_comb begin
    kind_next = KIND_RESEND;
    id_next   = cell_id[0];
    last_next = !stat.more;
    if (cmd.apply) begin
      id_next   = item_id;
      last_next = 1'b1;
      if (is_send) begin
        if (hit_found && hit_equal) begin
          kind_next = KIND_DROP_EQUAL;
        end else if (count == CNT_W'(TABLE_DEPTH)) begin
          kind_next = KIND_FULL;
        end else begin
          kind_next = KIND_QUEUED;
        end
      end else begin
        kind_next = hit_found ? KIND_REMOVED : KIND_NOT_FOUND;
      end
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      timeout   <= RESET_TIMEOUT;
      out_valid <= 1'b0;
      rs_cnt    <= '0;
    end else begin
      if (cfg_write_en) begin
        timeout <= cfg_write_data;
      end
      if (cmd.apply && send_ins) begin
        count <= count + CNT_W'(1);
      end else if (cmd.apply && rem) begin
        count <= count - CNT_W'(1);
      end
      if (cmd.load) begin
        rs_cnt <= '0;
      end else if (cmd.rotate) begin
        rs_cnt <= rs_cnt + RES_W'(1);
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // item, match and output payload
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_action <= action;
      item_id     <= packet_id;
      item_now    <= now_seconds;
    end
    if (cmd.match) begin
      hit_found <= first_found;
      hit_idx   <= first_idx;
      hit_equal <= first_equal;
    end
    if (out_load) begin
      kind          <= kind_next;
      packet_id_res <= id_next;
      last          <= last_next;
    end
  end

  // table cells: insert shifts toward the tail, remove and rotate shift toward the head
  for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
    always_ff @(posedge clk) begin
      if (cmd.apply && send_ins) begin
        if (IDX_W'(g) == ins_pos) begin
          cell_id[g]   <= item_id;
          cell_time[g] <= item_now;
        end else if (IDX_W'(g) > ins_pos) begin
          cell_id[g]   <= prev_id[g];
          cell_time[g] <= prev_time[g];
        end
      end else if (cmd.apply && rem) begin
        if (IDX_W'(g) >= hit_idx) begin
          cell_id[g]   <= next_id[g];
          cell_time[g] <= next_time[g];
        end
      end else if (cmd.rotate) begin
        if (CNT_W'(g + 1) < count) begin
          cell_id[g]   <= next_id[g];
          cell_time[g] <= next_time[g];
        end else if (CNT_W'(g + 1) == count) begin
          cell_id[g]   <= cell_id[0];
          cell_time[g] <= item_now;
        end
      end
    end
  end

endmodule

// ===== src/retransmit_timeout_table_unit.sv =====
// Retransmit timeout table, top level: holds up to TABLE_DEPTH (16) waiting packets ordered
// by queue time, oldest at the head. One item is worked at a time. A send or reply goes
// through latch, parallel compare over all cells, then the shift and result write; the
// write waits while the output register stays stalled. A timeout check resends the due
// entries one at a time (at most 16) and waits on a stalled output, since each resend
// moves one entry from the head to the tail through the shared cell row. There is no
// clearing pass after reset; cells beyond the fill count never affect a result.

module retransmit_timeout_table_unit import rtt_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_write_en,
  input  logic [TO_W-1:0]   cfg_write_data,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        action,
  input  logic [ID_W-1:0]   packet_id,
  input  logic [TIME_W-1:0] now_seconds,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [2:0]        kind,
  output logic [ID_W-1:0]   packet_id_res,
  output logic              last
);

  rtt_cmd_t  cmd;
  rtt_stat_t stat;

  rtt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .action   (action),
    .in_stall (in_stall),
    .cmd      (cmd),
    .stat     (stat)
  );

  rtt_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .stat           (stat),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data),
    .action         (action),
    .packet_id      (packet_id),
    .now_seconds    (now_seconds),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .kind           (kind),
    .packet_id_res  (packet_id_res),
    .last           (last)
  );

endmodule

// ===== src/rtt_checker.sv =====
// port-level checker of the retransmit timeout table, bound to the top level
// depends on rtt_pkg and on the port names of retransmit_timeout_table_unit

module rtt_checker import rtt_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_stall,
  input logic [1:0]        action,
  input logic [ID_W-1:0]   packet_id,
  input logic              out_valid,
  input logic              out_stall,
  input logic [2:0]        kind,
  input logic [ID_W-1:0]   packet_id_res,
  input logic              last
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(kind) && $stable(packet_id_res)
      && $stable(last))
    else $error("stalled result changed");

  // send answered after the match and apply states when the output was empty
  a_send_resp: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && action == ACT_SEND && !out_valid |-> ##3
      (out_valid && packet_id_res == $past(packet_id, 3)
       && (kind == KIND_QUEUED || kind == KIND_DROP_EQUAL || kind == KIND_FULL)))
    else $error("send result missing or wrong");

  // reply answered after the match and apply states when the output was empty
  a_reply_resp: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && action == ACT_REPLY && !out_valid |-> ##3
      (out_valid && packet_id_res == $past(packet_id, 3)
       && (kind == KIND_REMOVED || kind == KIND_NOT_FOUND)))
    else $error("reply result missing or wrong");

  // a resend burst continues without a gap and blocks new items
  a_burst: assert property (@(posedge clk) disable iff (rst)
    out_valid && !last |-> in_stall && kind == KIND_RESEND ##1 out_valid)
    else $error("resend burst broken");

endmodule

bind retransmit_timeout_table_unit rtt_checker u_rtt_checker (.*);

// ===== verif/rtt_table_checker.sv =====
// result checker for the retransmit timeout table: keeps its own copy of the ordered table
// and the timeout register, predicts every result and compares it with what the unit emits
// depends on rtt_pkg; instantiated by tb beside the unit
`timescale 1ns / 100ps

module rtt_table_checker import rtt_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_write_en,
  input  logic [TO_W-1:0]   cfg_write_data,
  input  logic              in_valid,
  input  logic              in_stall,
  input  logic [1:0]        action,
  input  logic [ID_W-1:0]   packet_id,
  input  logic [TIME_W-1:0] now_seconds,
  input  logic              out_valid,
  input  logic              out_stall,
  input  logic [2:0]        kind,
  input  logic [ID_W-1:0]   packet_id_res,
  input  logic              last,
  output int                fail_count,
  output int                pending
);

  typedef struct packed {
    logic [2:0]      kind;
    logic [ID_W-1:0] id;
    logic            last;
  } table_result_t;

  logic [ID_W-1:0]   slot_id   [TABLE_DEPTH];
  logic [TIME_W-1:0] slot_time [TABLE_DEPTH];
  int                fill;
  logic [TO_W-1:0]   timeout;
  table_result_t     awaited_results [$];
  table_result_t     oldest;

  function automatic void push_result(logic [2:0] k, logic [ID_W-1:0] id, logic l);
    awaited_results.insert(awaited_results.size(), '{kind: k, id: id, last: l});
  endfunction

  // entry time lies ahead of now in modular time
  function automatic bit later_than(logic [TIME_W-1:0] t, logic [TIME_W-1:0] now);
    logic [TIME_W-1:0] d;
    d = t - now;
    return (d != '0) && !d[TIME_W-1];
  endfunction

  function automatic void queue_packet(logic [ID_W-1:0] id, logic [TIME_W-1:0] now);
    int pos;
    pos = fill;
    for (int i = 0; i < fill; i++) begin
      if (later_than(slot_time[i], now)) begin
        pos = i;
        break;
      end
      if (slot_time[i] == now) begin
        push_result(KIND_DROP_EQUAL, id, 1'b1);
        return;
      end
    end
    if (fill >= TABLE_DEPTH) begin
      push_result(KIND_FULL, id, 1'b1);
      return;
    end
    for (int i = fill; i > pos; i--) begin
      slot_id[i]   = slot_id[i-1];
      slot_time[i] = slot_time[i-1];
    end
    slot_id[pos]   = id;
    slot_time[pos] = now;
    fill++;
    push_result(KIND_QUEUED, id, 1'b1);
  endfunction

  function automatic void ack_packet(logic [ID_W-1:0] id);
    for (int i = 0; i < fill; i++) begin
      if (slot_id[i] == id) begin
        for (int j = i; j + 1 < fill; j++) begin
          slot_id[j]   = slot_id[j+1];
          slot_time[j] = slot_time[j+1];
        end
        fill--;
        push_result(KIND_REMOVED, id, 1'b1);
        return;
      end
    end
    push_result(KIND_NOT_FOUND, id, 1'b1);
  endfunction

  function automatic void sweep_expired(logic [TIME_W-1:0] now);
    logic [ID_W-1:0]   due [MAX_RESULTS];
    logic [TIME_W-1:0] age;
    int                n;
    n = 0;
    while (n < fill && n < MAX_RESULTS) begin
      age = now - slot_time[n];
      if (age <= timeout) break;
      due[n] = slot_id[n];
      n++;
    end
    if (n == 0) return;
    for (int i = 0; i + n < fill; i++) begin
      slot_id[i]   = slot_id[i+n];
      slot_time[i] = slot_time[i+n];
    end
    // expired entries go to the tail restamped, order kept
    for (int i = 0; i < n; i++) begin
      slot_id[fill-n+i]   = due[i];
      slot_time[fill-n+i] = now;
      push_result(KIND_RESEND, due[i], i == n - 1);
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      fill       = 0;
      timeout    = RESET_TIMEOUT;
      fail_count = 0;
      awaited_results.delete();
    end else begin
      // results leave before the same edge's input is predicted
      if (out_valid && !out_stall) begin
        if (awaited_results.size() == 0) begin
          $error("unexpected result: kind %0d, packet_id_res %h, last %0d",
                 kind, packet_id_res, last);
          fail_count++;
        end else begin
          oldest = awaited_results.pop_front();
          if (kind !== oldest.kind) begin
            $error("kind: expected %0d, actual %0d", oldest.kind, kind);
            fail_count++;
          end
          if (packet_id_res !== oldest.id) begin
            $error("packet_id_res: expected %h, actual %h", oldest.id, packet_id_res);
            fail_count++;
          end
          if (last !== oldest.last) begin
            $error("last: expected %0d, actual %0d", oldest.last, last);
            fail_count++;
          end
        end
      end
      if (cfg_write_en) timeout = cfg_write_data;
      if (in_valid && !in_stall) begin
        case (action)
          ACT_SEND:  queue_packet(packet_id, now_seconds);
          ACT_REPLY: ack_packet(packet_id);
          ACT_CHECK: sweep_expired(now_seconds);
          default: ;
        endcase
      end
    end
    pending = awaited_results.size();
  end

endmodule

// ===== verif/tb.sv =====
// testbench top for retransmit_timeout_table_unit: drives directed and random packet, reply
// and timeout-check transfers with random idling, then gives the verdict
// depends on rtt_pkg, retransmit_timeout_table_unit and rtt_table_checker
`timescale 1ns / 100ps

module tb import rtt_pkg::*; ();

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 40;
  localparam int LONG_HOLD      = 400;
  localparam int PHASE_ITEMS    = 32;
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  logic              clk;
  logic              rst;
  logic              cfg_write_en;
  logic [TO_W-1:0]   cfg_write_data;
  logic              in_valid;
  logic              in_stall;
  logic [1:0]        action;
  logic [ID_W-1:0]   packet_id;
  logic [TIME_W-1:0] now_seconds;
  logic              out_valid;
  logic              out_stall;
  logic [2:0]        kind;
  logic [ID_W-1:0]   packet_id_res;
  logic              last;

  int                fail_count;
  int                pending;
  int                idle_cycles;
  bit                in_idle_on;
  bit                out_idle_on;
  bit                long_hold_req;
  logic [TO_W-1:0]   cur_timeout;
  logic [TIME_W-1:0] wall_clock;
  logic [ID_W-1:0]   live_ids [$];

  initial clk = 1'b0;
  always #5 clk = ~clk;

  retransmit_timeout_table_unit uut (
    .clk            (clk),
    .rst            (rst),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .action         (action),
    .packet_id      (packet_id),
    .now_seconds    (now_seconds),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .kind           (kind),
    .packet_id_res  (packet_id_res),
    .last           (last)
  );

  rtt_table_checker table_check (
    .clk            (clk),
    .rst            (rst),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .action         (action),
    .packet_id      (packet_id),
    .now_seconds    (now_seconds),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .kind           (kind),
    .packet_id_res  (packet_id_res),
    .last           (last),
    .fail_count     (fail_count),
    .pending        (pending)
  );

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic offer(input logic [1:0] act, input logic [ID_W-1:0] id,
                       input logic [TIME_W-1:0] t);
    int gap;
    in_valid    <= 1'b1;
    action      <= act;
    packet_id   <= id;
    now_seconds <= t;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    gap = in_idle_on ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // wait for the table to go quiet, then write the timeout
  task automatic drain_and_set(input logic [TO_W-1:0] value);
    in_valid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_write_en   <= 1'b1;
    cfg_write_data <= value;
    cur_timeout     = value;
    @(posedge clk);
    cfg_write_en   <= 1'b0;
  endtask

  task automatic random_item();
    int                r;
    int                s;
    int                idx;
    logic [TIME_W-1:0] step;
    logic [ID_W-1:0]   id;
    s = $urandom_range(0, 99);
    if (s < 25) step = '0;
    else if (s < 75) step = $urandom_range(1, int'(cur_timeout) / 4 + 1);
    else if (s < 97) step = $urandom_range(int'(cur_timeout), 2 * int'(cur_timeout) + 2);
    else step = $urandom;
    wall_clock += step;
    r = $urandom_range(0, 99);
    if (r < 40) begin
      id = $urandom;
      offer(ACT_SEND, id, wall_clock);
      live_ids.insert(live_ids.size(), id);
      if (live_ids.size() > 24) void'(live_ids.pop_front());
    end else if (r < 65) begin
      if (live_ids.size() > 0 && $urandom_range(0, 4) != 0) begin
        idx = $urandom_range(0, live_ids.size() - 1);
        id  = live_ids[idx];
        live_ids.delete(idx);
      end else begin
        id = $urandom;
      end
      offer(ACT_REPLY, id, $urandom);
    end else if (r < 88) begin
      offer(ACT_CHECK, $urandom, wall_clock);
    end else if (r < 95) begin
      // noise: arbitrary time unrelated to the running clock
      offer((r % 2) ? ACT_SEND : ACT_CHECK, $urandom, $urandom);
    end else begin
      offer(ACT_UNUSED, $urandom, $urandom);
    end
  endtask

  // receiver side
  initial begin
    out_stall = 1'b0;
    forever begin
      int hold;
      @(posedge clk);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold = LONG_HOLD;
      end else if (out_idle_on && $urandom_range(0, 2) == 0) begin
        hold = 1 + pick_gap();
      end else begin
        hold = 0;
      end
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("retransmit_timeout_table_unit regression: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    logic [TO_W-1:0] timeout_steps [5];
    bit              saved_idle;
    rst            = 1'b1;
    cfg_write_en   = 1'b0;
    cfg_write_data = '0;
    in_valid       = 1'b0;
    action         = ACT_SEND;
    packet_id      = '0;
    now_seconds    = '0;
    in_idle_on     = 1'b1;
    out_idle_on    = 1'b1;
    long_hold_req  = 1'b0;
    idle_cycles    = 0;
    cur_timeout    = RESET_TIMEOUT;
    wall_clock     = '0;
    timeout_steps[0] = '0;
    timeout_steps[1] = '1;
    timeout_steps[2] = $urandom_range(2, 500);
    timeout_steps[3] = 16'd1;
    timeout_steps[4] = RESET_TIMEOUT;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // directed part, timeout still at its reset value
    offer(ACT_SEND, 32'h0, 32'd100);
    offer(ACT_SEND, 32'hFFFF_FFFF, 32'd100);         // equal time is dropped
    offer(ACT_SEND, 32'd5, 32'd50);                  // earlier time goes to the head
    offer(ACT_SEND, 32'd6, 32'hFFFF_FFF0);           // just before zero across the wrap
    offer(ACT_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    offer(ACT_REPLY, 32'd7, 32'd0);                  // not in the table
    offer(ACT_REPLY, 32'd5, 32'd0);
    offer(ACT_CHECK, 32'd0, 32'd110);                // one aged out, one exactly at timeout
    offer(ACT_CHECK, 32'd0, 32'd110);                // nothing expired
    offer(ACT_CHECK, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    for (int i = 0; i < 15; i++) begin
      // fills the table, last one finds it full; a repeated id (loop index 3) sits at index 5
      offer(ACT_SEND, (i == 3) ? 32'h0 : $urandom, 32'd1000 + i);
    end
    offer(ACT_CHECK, 32'd0, 32'd5000);               // full table resent in one check
    offer(ACT_REPLY, 32'h0, 32'hFFFF_FFFF);          // first of two matching ids goes
    wall_clock = 32'd5000;

    for (int p = 0; p < 5; p++) begin
      drain_and_set(timeout_steps[p]);
      if (p == 0) begin
        in_idle_on  = 1'b1;
        out_idle_on = 1'b1;
      end else if (p == 2) begin
        in_idle_on  = 1'b0;
        out_idle_on = 1'b0;
      end else begin
        in_idle_on  = $urandom_range(0, 3) != 0;
        out_idle_on = $urandom_range(0, 3) != 0;
      end
      if (p == 1) begin
        // receiver holds off while the sender keeps pushing
        saved_idle    = in_idle_on;
        in_idle_on    = 1'b0;
        long_hold_req = 1'b1;
        repeat (12) random_item();
        in_idle_on    = saved_idle;
      end
      repeat (PHASE_ITEMS) random_item();
    end

    in_valid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("retransmit_timeout_table_unit regression: pass");
    end else begin
      $display("retransmit_timeout_table_unit regression: fail");
    end
    $finish;
  end

endmodule
